// ===== rtl/core/pdam_pkg.sv =====
// ----------------------------------------------------------------------------
// pdam_pkg
// Shared types and constants for the PWM duty averaging meter.
// ----------------------------------------------------------------------------
package pdam_pkg;

  localparam int unsigned CaptureW       = 16;
  localparam int unsigned SumW           = 22;
  localparam int unsigned DivisorW       = SumW - 1;
  localparam int unsigned DutyW          = 14;
  localparam int unsigned DutyShift      = 12;
  localparam int unsigned WindowCapturesDef = 32;

  // Serial step counts
  localparam int unsigned AccSteps = SumW;
  localparam int unsigned DivSteps = SumW + DutyShift;
  localparam int unsigned AccCntW  = $clog2(AccSteps);
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  typedef enum logic [1:0] {
    ACT_PERIOD  = 2'd0,
    ACT_HIGH    = 2'd1,
    ACT_QUERY   = 2'd2,
    ACT_RESTART = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_DIVIDE,
    ST_FINISH
  } state_e;

  typedef struct packed {
    action_e               action;
    logic [CaptureW-1:0]   capture_value;
  } in_word_t;

  typedef struct packed {
    logic                  window_full;
    logic [DutyW-1:0]      duty;
    logic                  divide_error;
  } out_word_t;

  typedef struct packed {
    logic start;
    logic clear;
  } acc_ctrl_t;

endpackage

// ===== rtl/core/pwm_duty_averaging_meter.sv =====
// ----------------------------------------------------------------------------
// pwm_duty_averaging_meter
// Averages PWM period and high-time captures over a window and reports duty.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o carry one word {action,
// capture_value}. Period (0) and high-time (1) captures add into 22-bit
// saturating sums until WINDOW_CAPTURES period captures are in; the window is
// then full and captures are ignored. A query (2) computes
// duty = (high_sum << 12) / (period_sum >> 1) when full and period_sum >=
// high_sum, flags divide_error on a zero divisor, else holds duty. A restart
// (3) clears sums, count and full flag; duty is kept.
// Output channel: out_valid_o / out_stall_i, exactly one word per input word.
// A capture runs through a 22-step bit-serial add and a query that divides
// through a 34-step restoring divider; other words go straight to the output.
// One word is in work at a time; the next word is taken as soon as the
// result sits in the output register, even if that is stalled.
// Reset clears sums, count, flags and duty. A stalled output holds its word.
// ----------------------------------------------------------------------------
module pwm_duty_averaging_meter #(
  parameter int unsigned WINDOW_CAPTURES = pdam_pkg::WindowCapturesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  pdam_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pdam_pkg::out_word_t out_word_o
);
  import pdam_pkg::*;

  localparam int unsigned CntW = (WINDOW_CAPTURES > 2) ? $clog2(WINDOW_CAPTURES) : 1;

  state_e          state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic            full_q, full_d;
  logic            err_q, err_d;
  logic [DutyW-1:0] duty_q, duty_d;
  logic            out_valid_q, out_valid_d;
  out_word_t       out_q, out_d;

  logic            in_fire, load_out;
  logic            p_start, h_start, div_start, err_set, restart, query_ok, div_zero;
  acc_ctrl_t       p_ctrl, h_ctrl;
  logic [SumW-1:0] period_sum, high_sum;
  logic            p_done, h_done, d_done;
  logic [DutyW-1:0] quot;

  // --- decode --------------------------------------------------------------
  always_comb begin
    in_fire   = in_valid_i && !in_stall_o;
    query_ok  = full_q && (period_sum >= high_sum);
    div_zero  = (period_sum[SumW-1:1] == '0);
    p_start   = in_fire && (in_word_i.action == ACT_PERIOD) && !full_q;
    h_start   = in_fire && (in_word_i.action == ACT_HIGH) && !full_q;
    div_start = in_fire && (in_word_i.action == ACT_QUERY) && query_ok && !div_zero;
    err_set   = (in_word_i.action == ACT_QUERY) && query_ok && div_zero;
    restart   = in_fire && (in_word_i.action == ACT_RESTART);
  end

  assign p_ctrl = '{start: p_start, clear: restart};
  assign h_ctrl = '{start: h_start, clear: restart};

  pdam_accum u_period (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (p_ctrl),
    .value_i (in_word_i.capture_value),
    .done_o  (p_done),
    .sum_o   (period_sum)
  );

  pdam_accum u_high (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (h_ctrl),
    .value_i (in_word_i.capture_value),
    .done_o  (h_done),
    .sum_o   (high_sum)
  );

  pdam_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (high_sum),
    .divisor_i  (period_sum[SumW-1:1]),
    .done_o     (d_done),
    .quot_o     (quot)
  );

  // --- next state ----------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (p_start || h_start) state_d = ST_ACCUM;
          else if (div_start)     state_d = ST_DIVIDE;
          else                    state_d = ST_FINISH;
        end
      end
      ST_ACCUM:  if (p_done || h_done) state_d = ST_FINISH;
      ST_DIVIDE: if (d_done) state_d = ST_FINISH;
      ST_FINISH: if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // --- FSM outputs ---------------------------------------------------------
  always_comb begin
    in_stall_o = 1'b1;
    load_out   = 1'b0;
    unique case (state_q)
      ST_IDLE:   in_stall_o = 1'b0;
      ST_ACCUM,
      ST_DIVIDE: ;
      ST_FINISH: load_out = !out_valid_q || !out_stall_i;
      default:   ;
    endcase
  end

  // --- window bookkeeping and result ---------------------------------------
  always_comb begin
    count_d = count_q;
    full_d  = full_q;
    err_d   = err_q;
    duty_d  = duty_q;
    if (in_fire) err_d = err_set;
    if (restart) begin
      count_d = '0;
      full_d  = 1'b0;
    end else if (p_start) begin
      if (count_q == CntW'(WINDOW_CAPTURES - 1)) begin
        count_d = '0;
        full_d  = 1'b1;
      end else begin
        count_d = count_q + CntW'(1);
      end
    end
    if (d_done) duty_d = quot;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (load_out) begin
      out_valid_d = 1'b1;
      out_d       = '{window_full: full_q, duty: duty_q, divide_error: err_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      full_q      <= 1'b0;
      err_q       <= 1'b0;
      duty_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      full_q      <= full_d;
      err_q       <= err_d;
      duty_q      <= duty_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // --- assertions ----------------------------------------------------------
  a_div_needs_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> (full_q && period_sum >= high_sum))
    else $error("divider started outside a full, valid window");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> in_stall_o)
    else $error("new word taken while previous word still in work");

  a_full_from_period: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full_q) |-> $past(p_start))
    else $error("window went full without a period capture");

  a_load_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !load_out)
    else $error("output register overwritten while stalled");

endmodule

// ===== rtl/core/pdam_accum.sv =====
// ----------------------------------------------------------------------------
// pdam_accum
// Bit-serial saturating accumulator: adds a capture into the sum one bit per
// cycle, LSB first, rotating the sum through a shift register.
// ----------------------------------------------------------------------------
module pdam_accum (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pdam_pkg::acc_ctrl_t         ctrl_i,
  input  logic [pdam_pkg::CaptureW-1:0] value_i,
  output logic                        done_o,
  output logic [pdam_pkg::SumW-1:0]   sum_o
);
  import pdam_pkg::*;

  logic [SumW-1:0]     sum_q, sum_d;
  logic [CaptureW-1:0] add_q, add_d;
  logic [AccCntW-1:0]  cnt_q, cnt_d;
  logic                carry_q, carry_d;
  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic                s_bit, c_out, last;

  always_comb begin
    s_bit = sum_q[0] ^ add_q[0] ^ carry_q;
    c_out = (sum_q[0] & add_q[0]) | (sum_q[0] & carry_q) | (add_q[0] & carry_q);
    last  = (cnt_q == AccCntW'(AccSteps - 1));

    sum_d   = sum_q;
    add_d   = add_q;
    cnt_d   = cnt_q;
    carry_d = carry_q;
    busy_d  = busy_q;
    done_d  = 1'b0;

    if (ctrl_i.clear) begin
      sum_d  = '0;
      busy_d = 1'b0;
    end else if (ctrl_i.start) begin
      add_d   = value_i;
      cnt_d   = '0;
      carry_d = 1'b0;
      busy_d  = 1'b1;
    end else if (busy_q) begin
      sum_d   = {s_bit, sum_q[SumW-1:1]};
      add_d   = add_q >> 1;
      carry_d = c_out;
      cnt_d   = cnt_q + AccCntW'(1);
      if (last) begin
        // carry out of the top bit: saturate
        if (c_out) sum_d = '1;
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      cnt_q   <= '0;
      carry_q <= 1'b0;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      sum_q   <= sum_d;
      cnt_q   <= cnt_d;
      carry_q <= carry_d;
      busy_q  <= busy_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    add_q <= add_d;
  end

  assign done_o = done_q;
  assign sum_o  = sum_q;

endmodule

// ===== rtl/core/pdam_divider.sv =====
// ----------------------------------------------------------------------------
// pdam_divider
// Restoring divider, one quotient bit per cycle. Divides (dividend << 12) by
// the divisor; the quotient saturates at the duty width.
// ----------------------------------------------------------------------------
module pdam_divider (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [pdam_pkg::SumW-1:0]     dividend_i,
  input  logic [pdam_pkg::DivisorW-1:0] divisor_i,
  output logic                          done_o,
  output logic [pdam_pkg::DutyW-1:0]    quot_o
);
  import pdam_pkg::*;

  logic [SumW-1:0]     num_q, num_d;
  logic [SumW-1:0]     rem_q, rem_d;
  logic [DivisorW-1:0] div_q, div_d;
  logic [DutyW-1:0]    quot_q, quot_d;
  logic                ovf_q, ovf_d;
  logic [DivCntW-1:0]  cnt_q, cnt_d;
  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [SumW-1:0]     rem_sh;
  logic                ge;

  always_comb begin
    rem_sh = {rem_q[SumW-2:0], num_q[SumW-1]};
    ge     = (rem_sh >= {1'b0, div_q});

    num_d  = num_q;
    rem_d  = rem_q;
    div_d  = div_q;
    quot_d = quot_q;
    ovf_d  = ovf_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;

    if (start_i) begin
      num_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
      quot_d = '0;
      ovf_d  = 1'b0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d  = num_q << 1;
      rem_d  = ge ? (rem_sh - {1'b0, div_q}) : rem_sh;
      quot_d = {quot_q[DutyW-2:0], ge};
      // a one shifted past the top means the quotient is out of range
      ovf_d  = ovf_q | quot_q[DutyW-1];
      cnt_d  = cnt_q + DivCntW'(1);
      if (cnt_q == DivCntW'(DivSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    rem_q  <= rem_d;
    div_q  <= div_d;
    quot_q <= quot_d;
    ovf_q  <= ovf_d;
  end

  assign done_o = done_q;
  assign quot_o = ovf_q ? '1 : quot_q;

endmodule
